// ===== src/plti_pkg.sv =====
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants for the piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

  // request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Q16.16 limits
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // quotient bits produced by the divider; larger quotients always saturate
  localparam int QBITS = 35;

  // controller to datapath commands
  typedef struct packed {
    logic load_entry;   // write request entry into the table
    logic latch_query;  // capture query value
    logic latch_a;      // capture entry k from the read port
    logic calc_diff;    // form magnitudes and sign from entries k, k+1
    logic mul;          // register |dy| * |dq|
    logic div_init;     // overflow check and divider setup
    logic div_step;     // one restoring division step
    logic add;          // add quotient to y[k] and clamp
    logic load_out;     // move result into the output register
  } plti_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic x_gt_q;  // breakpoint on the read port lies above the query
    logic flat;    // hold mode or zero-width segment
    logic big;     // quotient too wide for the divider bits; result saturates to the Q16.16 limits
  } plti_status_t;

endpackage

// ===== src/piecewise_linear_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Breakpoint table with linear interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// A load request (opcode 0) writes one table entry. A query request
// (opcode 1) runs a segment scan over the n active breakpoints, reading
// one entry per cycle through the table's single read port, and then a
// restoring divider that produces one quotient bit per cycle for 35 bits.
// Queries in hold mode, on a zero-width segment or past the last
// breakpoint skip the multiply and divide. One request is worked at a
// time; a finished result waits in the output register while the next
// request is taken. point_count is written through cfg_we/cfg_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Values below 2 act as 2 and above MAX_POINTS as
// MAX_POINTS. No clearing pass runs after reset; the table must be loaded
// before it is queried.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [5:0]         entry_index,
  input  logic signed [31:0] entry_x,
  input  logic signed [31:0] entry_y,
  input  logic               entry_interpolates,
  input  logic signed [31:0] query_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);
  import plti_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  plti_cmd_t     cmd;
  plti_status_t  status;
  logic [AW-1:0] rd_addr;

  // sequencer
  plti_controller #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  // table and arithmetic
  plti_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .rd_addr            (rd_addr),
    .entry_index        (entry_index),
    .entry_x            (entry_x),
    .entry_y            (entry_y),
    .entry_interpolates (entry_interpolates),
    .query_value        (query_value),
    .status             (status),
    .result_value       (result_value),
    .saturated          (saturated)
  );

endmodule

// ===== src/plti_datapath.sv =====
// ----------------------------------------------------------------------------
// plti_datapath
// Breakpoint table memory, query compare, multiplier, bit-serial divider
// and saturating result adder.
// ----------------------------------------------------------------------------
module plti_datapath #(
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk,
  input  plti_pkg::plti_cmd_t              cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]    rd_addr,
  input  logic [5:0]                       entry_index,
  input  logic signed [31:0]               entry_x,
  input  logic signed [31:0]               entry_y,
  input  logic                             entry_interpolates,
  input  logic signed [31:0]               query_value,
  output plti_pkg::plti_status_t           status,
  output logic signed [31:0]               result_value,
  output logic                             saturated
);
  import plti_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  // table storage
  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];
  logic               mem_m [MAX_POINTS];
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_y;
  logic               rd_m;

  // working registers
  logic signed [31:0] q;
  logic signed [31:0] xa;
  logic signed [31:0] ya;
  logic               mode_a;
  logic [31:0]        mag_dx;
  logic [31:0]        mag_dy;
  logic [31:0]        mag_dq;
  logic               neg;
  logic [63:0]        prod;
  logic [31:0]        rem;
  logic [QBITS-1:0]   dvd;
  logic signed [31:0] res;
  logic               res_sat;

  // combinational helpers
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] dq;
  logic [32:0]        abs_dx;
  logic [32:0]        abs_dy;
  logic [32:0]        abs_dq;
  logic [32:0]        shifted;
  logic               ge;
  logic [36:0]        tq;
  logic [36:0]        sum;
  logic               sat_hi;
  logic               sat_lo;

  // table write on load, registered read
  always_ff @(posedge clk) begin
    if (cmd.load_entry && (int'(entry_index) < MAX_POINTS)) begin
      mem_x[AW'(entry_index)] <= entry_x;
      mem_y[AW'(entry_index)] <= entry_y;
      mem_m[AW'(entry_index)] <= entry_interpolates;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_m <= mem_m[rd_addr];
  end

  // differences against entry k; read port holds entry k+1 here
  always_comb begin
    dx     = 33'(rd_x) - 33'(xa);
    dy     = 33'(rd_y) - 33'(ya);
    dq     = 33'(q) - 33'(xa);
    abs_dx = dx[32] ? -dx : dx;
    abs_dy = dy[32] ? -dy : dy;
    abs_dq = dq[32] ? -dq : dq;
  end

  // one restoring division step
  always_comb begin
    shifted = {rem, dvd[QBITS-1]};
    ge      = (shifted >= {1'b0, mag_dx});
  end

  // final add and clamp
  always_comb begin
    tq     = neg ? -{2'b00, dvd} : {2'b00, dvd};
    sum    = {{5{ya[31]}}, ya} + tq;
    sat_hi = !sum[36] && (|sum[35:31]);
    sat_lo = sum[36] && !(&sum[35:31]);
  end

  always_comb begin
    status.x_gt_q = (rd_x > q);
    status.flat   = !mode_a || (rd_x == xa);
    status.big    = ({3'b000, prod[63:QBITS]} >= mag_dx);
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.latch_query) begin
      q <= query_value;
    end
    if (cmd.latch_a) begin
      xa     <= rd_x;
      ya     <= rd_y;
      mode_a <= rd_m;
    end
    if (cmd.calc_diff) begin
      mag_dx  <= abs_dx[31:0];
      mag_dy  <= abs_dy[31:0];
      mag_dq  <= abs_dq[31:0];
      neg     <= dy[32] ^ dq[32] ^ dx[32];
      res     <= ya;
      res_sat <= 1'b0;
    end
    if (cmd.mul) begin
      prod <= mag_dy * mag_dq;
    end
    if (cmd.div_init) begin
      rem <= {3'b000, prod[63:QBITS]};
      dvd <= prod[QBITS-1:0];
      if (status.big) begin
        res     <= neg ? Q_MIN : Q_MAX;
        res_sat <= 1'b1;
      end
    end
    if (cmd.div_step) begin
      rem <= ge ? 32'(shifted - {1'b0, mag_dx}) : shifted[31:0];
      dvd <= {dvd[QBITS-2:0], ge};
    end
    if (cmd.add) begin
      if (sat_hi) begin
        res     <= Q_MAX;
        res_sat <= 1'b1;
      end else if (sat_lo) begin
        res     <= Q_MIN;
        res_sat <= 1'b1;
      end else begin
        res     <= sum[31:0];
        res_sat <= 1'b0;
      end
    end
    if (cmd.load_out) begin
      result_value <= res;
      saturated    <= res_sat;
    end
  end

endmodule

// ===== src/plti_controller.sv =====
// ----------------------------------------------------------------------------
// plti_controller
// Request handshake, point count register, segment scan and sequencing of
// the datapath; owns the output valid flag.
// ----------------------------------------------------------------------------
module plti_controller #(
  parameter int MAX_POINTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  output logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           cfg_we,
  input  logic [6:0]                     cfg_wdata,
  input  plti_pkg::plti_status_t         status,
  output plti_pkg::plti_cmd_t            cmd,
  output logic [$clog2(MAX_POINTS)-1:0]  rd_addr
);
  import plti_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN     = 4'd1;
  localparam logic [3:0] ST_RD_A     = 4'd2;
  localparam logic [3:0] ST_RD_B     = 4'd3;
  localparam logic [3:0] ST_DIFF     = 4'd4;
  localparam logic [3:0] ST_MUL      = 4'd5;
  localparam logic [3:0] ST_DIV_INIT = 4'd6;
  localparam logic [3:0] ST_DIV      = 4'd7;
  localparam logic [3:0] ST_ADD      = 4'd8;
  localparam logic [3:0] ST_FIN      = 4'd9;

  logic [3:0]    state;
  logic [3:0]    state_next;
  logic [6:0]    point_count;
  logic [CW-1:0] n_act;
  logic [CW-1:0] n_act_next;
  logic [CW-1:0] n_clamp;
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] scan_idx_next;
  logic [CW-1:0] cmp_idx;
  logic [CW-1:0] cmp_idx_next;
  logic          cmp_valid;
  logic          cmp_valid_next;
  logic [AW-1:0] k;
  logic [AW-1:0] k_next;
  logic [5:0]    div_cnt;
  logic [5:0]    div_cnt_next;
  logic          out_valid_next;
  logic          in_acc;
  logic          k_last;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign k_last   = (CW'(k) == n_act - CW'(1));

  // active breakpoint count, clamped to at least 2 and at most the table size
  always_comb begin
    if (point_count < 7'd2) begin
      n_clamp = CW'(2);
    end else if (int'(point_count) > MAX_POINTS) begin
      n_clamp = CW'(MAX_POINTS);
    end else begin
      n_clamp = CW'(point_count);
    end
  end

  // sequencing
  always_comb begin
    state_next     = state;
    n_act_next     = n_act;
    scan_idx_next  = scan_idx;
    cmp_idx_next   = cmp_idx;
    cmp_valid_next = cmp_valid;
    k_next         = k;
    div_cnt_next   = div_cnt;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    rd_addr        = scan_idx[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode == OP_QUERY) begin
            cmd.latch_query = 1'b1;
            n_act_next      = n_clamp;
            scan_idx_next   = CW'(1);
            cmp_valid_next  = 1'b0;
            k_next          = '0;
            state_next      = ST_SCAN;
          end else begin
            cmd.load_entry = 1'b1;
          end
        end
      end
      // one read per cycle; the compare sees each address in the cycle after it is issued
      ST_SCAN: begin
        scan_idx_next  = scan_idx + CW'(1);
        cmp_idx_next   = scan_idx;
        cmp_valid_next = 1'b1;
        if (cmp_valid) begin
          if (status.x_gt_q) begin
            state_next = ST_RD_A;
          end else begin
            k_next = cmp_idx[AW-1:0];
            if (cmp_idx == n_act - CW'(1)) begin
              state_next = ST_RD_A;
            end
          end
        end
      end
      ST_RD_A: begin
        rd_addr    = k;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        rd_addr     = k + AW'(1);
        cmd.latch_a = 1'b1;
        state_next  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_next    = (k_last || status.flat) ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        div_cnt_next = '0;
        state_next   = status.big ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 6'd1;
        if (div_cnt == 6'(QBITS - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_FIN;
      end
      // wait for the output register to free up
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      point_count <= 7'd2;
      cmp_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cmp_valid <= cmp_valid_next;
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_act    <= n_act_next;
    scan_idx <= scan_idx_next;
    cmp_idx  <= cmp_idx_next;
    k        <= k_next;
    div_cnt  <= div_cnt_next;
  end

`ifndef SYNTHESIS
  // a query closes the input side on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_QUERY) |=> in_stall)
    else $error("query did not start the sequencer");

  // divider count stays within the quotient width
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_cnt < 6'(QBITS)))
    else $error("divider ran past its last step");

  // selected segment lies inside the active table
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_A) |-> (CW'(k) < n_act))
    else $error("segment index beyond point count");

  // a result appears only from the final state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FIN))
    else $error("output valid raised outside final state");
`endif

endmodule
